// File: rtl/lrd_pkg.sv
// Shared types, codes and constants of the 64-bit LCG random draw unit.
// Used by every module of the block; depends on nothing else.
package lrd_pkg;

	// Request codes on the action field.
	localparam logic [2:0] ACT_SEED  = 3'd0;
	localparam logic [2:0] ACT_RAW   = 3'd1;
	localparam logic [2:0] ACT_BELOW = 3'd2;
	localparam logic [2:0] ACT_RANGE = 3'd3;
	localparam logic [2:0] ACT_FRAC  = 3'd4;

	// Generator step and seed mixer constants.
	localparam logic [63:0] LCG_MUL  = 64'd6364136223846793005;
	localparam logic [63:0] LCG_INC  = 64'd1442695040888963407;
	localparam logic [63:0] MIX_ADD  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_MUL1 = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL2 = 64'h94D0_49BB_1331_11EB;

	// Largest span that still goes through the unbiased rejection path.
	localparam logic [32:0] SPAN_NARROW_MAX = 33'h0_7FFF_FFFF;

	// Command queue between the front and back parts.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Remainder unit: one quotient bit per cycle over a 32-bit dividend.
	localparam int REM_STEPS = 32;
	localparam int REM_CNT_W = $clog2(REM_STEPS + 1);

	typedef enum logic [2:0] {
		K_CONST,
		K_SEED,
		K_RAW,
		K_BELOW,
		K_WIDE,
		K_FRAC
	} kind_t;

	// One classified request. arg is the seed, the bound or the span; lo is
	// the offset added to a bounded result, or the whole result of K_CONST.
	typedef struct packed {
		kind_t       kind;
		logic [32:0] arg;
		logic [31:0] lo;
	} cmd_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] k;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [32:0] den;
	} rem_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] rem;
	} rem_rsp_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_LL,
		M_LH,
		M_HL,
		M_SUM
	} mul_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DISP,
		B_THR,
		B_DSTART,
		B_DRAW,
		B_GOT,
		B_MOD,
		B_SEED0,
		B_SEED1,
		B_SEED2,
		B_SEED3,
		B_PUT
	} back_state_t;

	function automatic logic [53:0] sext54(input logic [31:0] x);
		return {{22{x[31]}}, x};
	endfunction

endpackage

// File: rtl/lrd_front.sv
// Front part: takes request transfers and classifies them into commands.
// Depends on lrd_pkg; feeds lrd_queue.
module lrd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         action,
	input  logic [31:0]        seed_value,
	input  logic signed [31:0] bound_n,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	input  logic               q_full,
	output logic               q_push,
	output lrd_pkg::cmd_t      q_cmd
);
	import lrd_pkg::*;

	logic        valid_s1;
	cmd_t        cmd_s1;
	cmd_t        cmd_c;
	logic [32:0] span;
	logic        hi_gt_lo;
	logic        take;

	assign req_stall = valid_s1 && q_full;
	assign take      = req_valid && !req_stall;
	assign q_push    = valid_s1 && !q_full;
	assign q_cmd     = cmd_s1;

	// The span is only used when high is above low, so it is 2..2^32.
	assign span     = {range_high[31], range_high} - {range_low[31], range_low} + 33'd1;
	assign hi_gt_lo = range_high > range_low;

	always_comb begin
		cmd_c.kind = K_CONST;
		cmd_c.arg  = '0;
		cmd_c.lo   = '0;
		unique case (action)
			ACT_SEED: begin
				cmd_c.kind = K_SEED;
				cmd_c.arg  = {1'b0, seed_value};
			end
			ACT_RAW: begin
				cmd_c.kind = K_RAW;
			end
			ACT_BELOW: begin
				if (bound_n > 32'sd0) begin
					cmd_c.kind = K_BELOW;
					cmd_c.arg  = {1'b0, bound_n};
				end
			end
			ACT_RANGE: begin
				cmd_c.lo = range_low;
				if (hi_gt_lo) begin
					cmd_c.arg  = span;
					cmd_c.kind = (span > SPAN_NARROW_MAX) ? K_WIDE : K_BELOW;
				end
			end
			ACT_FRAC: begin
				cmd_c.kind = K_FRAC;
			end
			default: begin
				cmd_c.kind = K_CONST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule

// File: rtl/lrd_queue.sv
// Short command queue that decouples the front part from the back part.
// Depends on lrd_pkg for the command type and depth.
module lrd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lrd_pkg::cmd_t push_cmd,
	input  logic          pop,
	output lrd_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);
	import lrd_pkg::*;

	cmd_t                entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_q;
	logic [Q_PTR_W-1:0]  rd_q;
	logic [Q_CNT_W-1:0]  cnt_q;

	assign full  = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue read while empty");

endmodule

// File: rtl/lrd_mul.sv
// Sequential 64x64 multiplier giving the low 64 bits of the product,
// built on one shared 32x32 multiplier. Depends on lrd_pkg.
module lrd_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  lrd_pkg::mul_req_t req,
	output lrd_pkg::mul_rsp_t rsp
);
	import lrd_pkg::*;

	mul_state_t  st_q, st_d;
	logic [63:0] a_q, k_q;
	logic [63:0] mp_q;
	logic [63:0] p0_q;
	logic [31:0] cross_q;
	logic [63:0] prod_q;
	logic        done_q;
	logic [31:0] op_x, op_y;

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			M_IDLE:  if (req.start) st_d = M_LL;
			M_LL:    st_d = M_LH;
			M_LH:    st_d = M_HL;
			M_HL:    st_d = M_SUM;
			M_SUM:   st_d = M_IDLE;
			default: st_d = M_IDLE;
		endcase
	end

	// Partial products in turn: low x low, low x high, high x low. The
	// high x high term only reaches bits above 63 and is never formed.
	always_comb begin
		op_x = a_q[31:0];
		op_y = k_q[31:0];
		unique case (st_q)
			M_LH: begin
				op_x = a_q[31:0];
				op_y = k_q[63:32];
			end
			M_HL: begin
				op_x = a_q[63:32];
				op_y = k_q[31:0];
			end
			default: begin
				op_x = a_q[31:0];
				op_y = k_q[31:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= st_q == M_SUM;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == M_IDLE && req.start) begin
			a_q <= req.a;
			k_q <= req.k;
		end
		mp_q <= op_x * op_y;
		if (st_q == M_LH) begin
			p0_q <= mp_q;
		end
		if (st_q == M_HL) begin
			cross_q <= mp_q[31:0];
		end
		if (st_q == M_SUM) begin
			prod_q <= {p0_q[63:32] + cross_q + mp_q[31:0], p0_q[31:0]};
		end
	end

endmodule

// File: rtl/lrd_rem.sv
// Restoring remainder unit: 32-bit dividend by a 33-bit divisor, one
// quotient bit per cycle. Depends on lrd_pkg.
module lrd_rem (
	input  logic              clk,
	input  logic              arst_n,
	input  lrd_pkg::rem_req_t req,
	output lrd_pkg::rem_rsp_t rsp
);
	import lrd_pkg::*;

	logic [31:0]          num_q;
	logic [32:0]          den_q;
	logic [32:0]          rem_q;
	logic [REM_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [33:0]          trial;
	logic [33:0]          diff;

	assign trial    = {rem_q, num_q[31]};
	assign diff     = trial - {1'b0, den_q};
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == REM_CNT_W'(1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= REM_CNT_W'(REM_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == REM_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so it fits 33 bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= diff[32:0];
			end else begin
				rem_q <= trial[32:0];
			end
		end
	end

endmodule

// File: rtl/lrd_back.sv
// Back part: holds the generator state and carries out one command at a
// time with the multiplier and remainder units. Depends on lrd_pkg.
module lrd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  lrd_pkg::cmd_t      q_head,
	output logic               q_pop,
	output lrd_pkg::mul_req_t  mul_req,
	input  lrd_pkg::mul_rsp_t  mul_rsp,
	output lrd_pkg::rem_req_t  rem_req,
	input  lrd_pkg::rem_rsp_t  rem_rsp,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [53:0] value
);
	import lrd_pkg::*;

	back_state_t fsm_q, fsm_d;
	cmd_t        cmd_q;
	logic [63:0] gen_q;
	logic [63:0] z_q;
	logic [31:0] thr_q;
	logic [26:0] frac_q;
	logic        half_q;
	logic [53:0] res_q;
	logic        rsp_valid_q;
	logic [53:0] value_q;
	logic [31:0] draw;
	logic        draw_ok;
	logic        slot_free;
	logic [31:0] sum_lo;

	assign draw      = gen_q[63:32];
	assign draw_ok   = draw >= thr_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign sum_lo    = cmd_q.lo + rem_rsp.rem;
	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;

	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			B_IDLE: begin
				if (!q_empty) fsm_d = B_DISP;
			end
			B_DISP: begin
				unique case (cmd_q.kind)
					K_CONST: fsm_d = B_PUT;
					K_SEED:  fsm_d = B_SEED0;
					K_BELOW: fsm_d = B_THR;
					default: fsm_d = B_DSTART;
				endcase
			end
			B_THR: begin
				if (rem_rsp.done) fsm_d = B_DSTART;
			end
			B_DSTART: fsm_d = B_DRAW;
			B_DRAW: begin
				if (mul_rsp.done) fsm_d = B_GOT;
			end
			B_GOT: begin
				unique case (cmd_q.kind)
					K_FRAC:  fsm_d = half_q ? B_PUT : B_DSTART;
					K_WIDE:  fsm_d = B_MOD;
					K_BELOW: fsm_d = draw_ok ? B_MOD : B_DSTART;
					default: fsm_d = B_PUT;
				endcase
			end
			B_MOD: begin
				if (rem_rsp.done) fsm_d = B_PUT;
			end
			B_SEED0: fsm_d = B_SEED1;
			B_SEED1: begin
				if (mul_rsp.done) fsm_d = B_SEED2;
			end
			B_SEED2: fsm_d = B_SEED3;
			B_SEED3: begin
				if (mul_rsp.done) fsm_d = B_PUT;
			end
			B_PUT: begin
				if (slot_free) fsm_d = B_IDLE;
			end
			default: fsm_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop         = fsm_q == B_IDLE && !q_empty;
		mul_req.start = 1'b0;
		mul_req.a     = gen_q;
		mul_req.k     = LCG_MUL;
		rem_req.start = 1'b0;
		rem_req.num   = draw;
		rem_req.den   = cmd_q.arg;
		unique case (fsm_q)
			B_DISP: begin
				// Rejection threshold is (2^32 - n) mod n.
				rem_req.start = cmd_q.kind == K_BELOW;
				rem_req.num   = 32'd0 - cmd_q.arg[31:0];
			end
			B_DSTART: begin
				mul_req.start = 1'b1;
			end
			B_GOT: begin
				rem_req.start = cmd_q.kind == K_WIDE || (cmd_q.kind == K_BELOW && draw_ok);
			end
			B_SEED0: begin
				mul_req.start = 1'b1;
				mul_req.a     = z_q ^ (z_q >> 30);
				mul_req.k     = MIX_MUL1;
			end
			B_SEED2: begin
				mul_req.start = 1'b1;
				mul_req.a     = z_q ^ (z_q >> 27);
				mul_req.k     = MIX_MUL2;
			end
			default: begin
				mul_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= B_IDLE;
			gen_q       <= '0;
			half_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (fsm_q == B_DISP) begin
				half_q <= 1'b0;
			end
			if (fsm_q == B_GOT && cmd_q.kind == K_FRAC) begin
				half_q <= 1'b1;
			end
			if (fsm_q == B_DRAW && mul_rsp.done) begin
				gen_q <= mul_rsp.prod + LCG_INC;
			end
			if (fsm_q == B_SEED3 && mul_rsp.done) begin
				gen_q <= mul_rsp.prod ^ (mul_rsp.prod >> 31);
			end
			if (fsm_q == B_PUT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (fsm_q)
			B_IDLE: begin
				if (q_pop) cmd_q <= q_head;
			end
			B_DISP: begin
				if (cmd_q.kind == K_SEED) begin
					res_q <= '0;
					z_q   <= {32'd0, cmd_q.arg[31:0]} + MIX_ADD;
				end else begin
					res_q <= sext54(cmd_q.lo);
				end
			end
			B_THR: begin
				if (rem_rsp.done) thr_q <= rem_rsp.rem;
			end
			B_GOT: begin
				if (cmd_q.kind == K_RAW) begin
					res_q <= {22'd0, draw};
				end
				if (cmd_q.kind == K_FRAC) begin
					if (half_q) begin
						res_q <= {1'b0, frac_q, draw[31:6]};
					end else begin
						frac_q <= draw[31:5];
					end
				end
			end
			B_MOD: begin
				if (rem_rsp.done) res_q <= sext54(sum_lo);
			end
			B_SEED1: begin
				if (mul_rsp.done) z_q <= mul_rsp.prod;
			end
			B_PUT: begin
				if (slot_free) value_q <= res_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (fsm_q == B_DRAW || fsm_q == B_SEED1 || fsm_q == B_SEED3))
		else $error("multiplier finished while no step waited for it");

	a_rem_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> (fsm_q == B_THR || fsm_q == B_MOD))
		else $error("remainder unit finished while no step waited for it");

	a_gen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == B_IDLE || fsm_q == B_PUT) |=> $stable(gen_q))
		else $error("generator state changed outside a draw or seed");

endmodule

// File: rtl/lcg64_random_draw_unit.sv
// Top level of the 64-bit LCG random draw unit: front, queue, back part,
// multiplier and remainder units. Depends on lrd_pkg and all lrd_ modules.
//
// Requests arrive on req_valid/req_stall with action, seed_value, bound_n,
// range_low and range_high; each request gives exactly one result transfer
// on rsp_valid/rsp_stall carrying value. A request is taken when req_valid
// is high and req_stall is low; a result moves when rsp_valid is high and
// rsp_stall is low. The front registers and classifies each request into
// a two-entry command queue, so requests keep being taken while the back
// part works and while a finished result waits at the output register.
// Work runs one command at a time in the back part. Each draw is one
// 64-bit LCG step on a shared 32x32 multiplier. A raw request takes one
// draw, a fraction two draws and a seed two mixer multiplications; the
// constant cases take none. Bounded and narrow range requests also work
// out the rejection threshold and a final remainder, redrawing while the
// draw falls under the threshold; a wide range adds one remainder.
// Reset clears the generator state to zero, empties the queue and drops
// any pending result. While rsp_stall is high the result holds, the back
// part waits with its next result, and req_stall rises once the queue
// fills.
module lcg64_random_draw_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         action,
	input  logic [31:0]        seed_value,
	input  logic signed [31:0] bound_n,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [53:0] value
);
	import lrd_pkg::*;

	logic     q_full;
	logic     q_empty;
	logic     q_push;
	logic     q_pop;
	cmd_t     push_cmd;
	cmd_t     head_cmd;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	lrd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.seed_value (seed_value),
		.bound_n    (bound_n),
		.range_low  (range_low),
		.range_high (range_high),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	lrd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	lrd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	lrd_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	lrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head_cmd),
		.q_pop     (q_pop),
		.mul_req   (mul_req),
		.mul_rsp   (mul_rsp),
		.rem_req   (rem_req),
		.rem_rsp   (rem_rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value     (value)
	);

endmodule

// File: verif/lrd_draw_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the 64-bit LCG random draw unit: keeps its own generator
// state, predicts the value of every request and checks the result channel.
// Depends on lrd_pkg for the action codes.
module lrd_draw_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [2:0]         action,
	input  logic [31:0]        seed_value,
	input  logic signed [31:0] bound_n,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic signed [53:0] value,
	output int                 fail_count,
	output int                 outstanding
);

	localparam logic [63:0] STEP_MULT  = 64'd6364136223846793005;
	localparam logic [63:0] STEP_ADD   = 64'd1442695040888963407;
	localparam logic [63:0] SEED_ADD   = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] SEED_MULT1 = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] SEED_MULT2 = 64'h94D0_49BB_1331_11EB;
	localparam logic [63:0] NARROW_MAX = 64'h0000_0000_7FFF_FFFF;

	logic [63:0] gen_state;
	logic [53:0] expected_values[$];
	logic [53:0] want;

	function automatic logic [31:0] next_draw();
		gen_state = gen_state * STEP_MULT + STEP_ADD;
		return gen_state[63:32];
	endfunction

	// Unbiased draw below n: draws under (2^32 mod n) are thrown away.
	function automatic logic [31:0] draw_below(input logic [31:0] n);
		logic [31:0] reject_under;
		logic [31:0] r;
		reject_under = (32'd0 - n) % n;
		r = next_draw();
		while (r < reject_under)
			r = next_draw();
		return r % n;
	endfunction

	function automatic logic [53:0] predict_draw_value(
		input logic [2:0]         act,
		input logic [31:0]        seed,
		input logic signed [31:0] n,
		input logic signed [31:0] lo,
		input logic signed [31:0] hi
	);
		logic [63:0] z;
		logic [63:0] span;
		logic [63:0] outcome;
		logic [31:0] first_draw;
		logic [31:0] second_draw;
		longint      lo_x;
		longint      hi_x;
		outcome = '0;
		case (act)
		lrd_pkg::ACT_SEED: begin
			z = {32'd0, seed} + SEED_ADD;
			z = (z ^ (z >> 30)) * SEED_MULT1;
			z = (z ^ (z >> 27)) * SEED_MULT2;
			gen_state = z ^ (z >> 31);
		end
		lrd_pkg::ACT_RAW: begin
			outcome = {32'd0, next_draw()};
		end
		lrd_pkg::ACT_BELOW: begin
			if (n > 0)
				outcome = {32'd0, draw_below(n)};
		end
		lrd_pkg::ACT_RANGE: begin
			lo_x = lo;
			hi_x = hi;
			if (hi_x <= lo_x) begin
				outcome = lo_x;
			end else begin
				span = hi_x - lo_x + 1;
				// Spans past 2^31-1 take one plain modulo, bias and all.
				if (span > NARROW_MAX)
					outcome = lo_x + ({32'd0, next_draw()} % span);
				else
					outcome = lo_x + {32'd0, draw_below(span[31:0])};
			end
		end
		lrd_pkg::ACT_FRAC: begin
			first_draw = next_draw();
			second_draw = next_draw();
			outcome = {11'd0, first_draw[31:5], second_draw[31:6]};
		end
		default: begin
			outcome = '0;
		end
		endcase
		return outcome[53:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_state = '0;
			expected_values.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			// Check the result first: it can never belong to a request taken at this edge.
			if (rsp_valid && !rsp_stall) begin
				if (expected_values.size() == 0) begin
					$display("%0t: result transfer with nothing expected, actual %h",
						$time, value);
					fail_count++;
				end else begin
					want = expected_values.pop_front();
					if (value !== want) begin
						$display("%0t: value mismatch, expected %h, actual %h",
							$time, want, value);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_values.push_back(predict_draw_value(action, seed_value,
					bound_n, range_low, range_high));
			outstanding = expected_values.size();
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for the 64-bit LCG random draw unit: clock, reset,
// request and result drivers, watchdog and verdict.
// Depends on lrd_pkg, lcg64_random_draw_unit and lrd_draw_checker.
module testbench;

	localparam int RANDOM_ITEMS   = 1200;
	localparam int IDLE_PCT       = 18;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 200;

	// Action codes that the block does not define.
	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [2:0]         action = '0;
	logic [31:0]        seed_value = '0;
	logic signed [31:0] bound_n = '0;
	logic signed [31:0] range_low = '0;
	logic signed [31:0] range_high = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic signed [53:0] value;
	logic               steady = 1'b0;
	int                 fail_count;
	int                 outstanding;

	always #1 clk = ~clk;

	lcg64_random_draw_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.seed_value (seed_value),
		.bound_n    (bound_n),
		.range_low  (range_low),
		.range_high (range_high),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.value      (value)
	);

	lrd_draw_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.seed_value  (seed_value),
		.bound_n     (bound_n),
		.range_low   (range_low),
		.range_high  (range_high),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.value       (value),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always @(negedge clk) begin
		rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	// Called at a falling edge; returns at a falling edge after the transfer
	// and any idle cycles that follow it.
	task automatic send_request(input logic [2:0] act, input logic [31:0] seed,
		input logic [31:0] n, input logic [31:0] lo, input logic [31:0] hi);
		req_valid <= 1'b1;
		action <= act;
		seed_value <= seed;
		bound_n <= n;
		range_low <= lo;
		range_high <= hi;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("[lcg64_random_draw_unit] ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [2:0]  act;
		logic [31:0] roll;
		logic [31:0] seed;
		logic [31:0] n;
		logic [31:0] lo;
		logic [31:0] hi;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Draws from the unseeded all-zero state come first.
		send_request(lrd_pkg::ACT_RAW, 32'h0, 32'h0, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_FRAC, 32'h0, 32'h0, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_SEED, 32'h0, 32'h0, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_RAW, 32'h0, 32'h0, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_SEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(lrd_pkg::ACT_BELOW, 32'h0, 32'd1, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_BELOW, 32'h0, 32'd0, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_BELOW, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_BELOW, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_BELOW, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_BELOW, 32'h0, 32'd3, 32'h0, 32'h0);
		// A quarter of all draws fall under the rejection cut for this bound.
		send_request(lrd_pkg::ACT_BELOW, 32'h0, 32'h4000_0001, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_RANGE, 32'h0, 32'h0, 32'd7, 32'd7);
		send_request(lrd_pkg::ACT_RANGE, 32'h0, 32'h0, 32'd9, 32'hFFFF_FFF6);
		send_request(lrd_pkg::ACT_RANGE, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(lrd_pkg::ACT_RANGE, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFE);
		send_request(lrd_pkg::ACT_RANGE, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFE);
		send_request(lrd_pkg::ACT_RANGE, 32'h0, 32'h0, 32'hFFFF_FFFB, 32'd5);
		send_request(lrd_pkg::ACT_RANGE, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(lrd_pkg::ACT_RANGE, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0001);
		send_request(lrd_pkg::ACT_FRAC, 32'h0, 32'h0, 32'h0, 32'h0);
		send_request(ACT_UNUSED_LO, 32'h0, 32'h0, 32'h0, 32'h0);
		send_request(ACT_UNUSED_LO + 3'd1, 32'h0, 32'h0, 32'h0, 32'h0);
		send_request(ACT_UNUSED_HI, 32'h0, 32'h0, 32'h0, 32'h0);
		send_request(lrd_pkg::ACT_SEED, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
		hold_until_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300 || i == 800)
				hold_until_drained();
			steady <= (i >= 400 && i < 600);
			seed = $urandom();
			n = $urandom();
			lo = $urandom();
			hi = $urandom();
			roll = $urandom_range(99);
			if (roll < 8) begin
				act = lrd_pkg::ACT_SEED;
			end else if (roll < 25) begin
				act = lrd_pkg::ACT_RAW;
			end else if (roll < 50) begin
				act = lrd_pkg::ACT_BELOW;
				roll = $urandom_range(3);
				case (roll[1:0])
				2'd0: n = $urandom_range(16, 1);
				2'd1: n = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
				2'd2: n = $urandom_range(1000, 1);
				default: n = $urandom();
				endcase
			end else if (roll < 82) begin
				act = lrd_pkg::ACT_RANGE;
				roll = $urandom_range(3);
				case (roll[1:0])
				2'd0: hi = lo + $urandom_range(20);
				2'd1: begin
					// Negative low end and positive high end often give wide spans.
					lo[31] = 1'b1;
					hi[31] = 1'b0;
				end
				2'd2: hi = lo + $urandom_range(32'h7FFF_FFFE, 32'h4000_0000);
				default: hi = $urandom();
				endcase
			end else if (roll < 94) begin
				act = lrd_pkg::ACT_FRAC;
			end else begin
				roll = $urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO);
				act = roll[2:0];
			end
			send_request(act, seed, n, lo, hi);
		end

		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("[lcg64_random_draw_unit] OK");
		else
			$display("[lcg64_random_draw_unit] ERROR");
		$finish;
	end

endmodule

// File: lcg64_random_draw_unit.f
rtl/lrd_pkg.sv
rtl/lrd_front.sv
rtl/lrd_queue.sv
rtl/lrd_mul.sv
rtl/lrd_rem.sv
rtl/lrd_back.sv
rtl/lcg64_random_draw_unit.sv
verif/lrd_draw_checker.sv
verif/testbench.sv
